FILE: rtl/core/slif_pkg.sv
`default_nettype none
package slif_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int ITEM_W      = 32;
   localparam int LENGTH_W    = 7;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W       = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PUSH   = 2'd1,
      OP_FIND   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      op_type                   operation;
      logic signed [ITEM_W-1:0] item;
   } req_type;

   typedef struct packed {
      logic                found;
      logic                full_drop;
      logic [LENGTH_W-1:0] length;
   } rsp_type;

   // broadcast to every cell in the update cycle
   typedef struct packed {
      logic             insert;
      logic             clear;
      logic [LEN_W-1:0] pos;
      logic [LEN_W-1:0] len;
      value_type        item;
   } ctl_type;

   // per-cell compare results, registered at request accept
   typedef struct packed {
      logic lt;
      logic pair;
      logic hit;
   } stat_type;

   function automatic value_type to_value(input logic signed [ITEM_W-1:0] item);
      return value_type'(item);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sorted_list_insert_find.sv
// Sorted list with ordered insert, push front, find and clear, held in a
// row of cells, one stored value per cell, cell 0 being the head.
// Request channel: req_valid, req_stall, req_data (operation, item).
// Response channel: rsp_valid, rsp_stall, rsp_data (found, full_drop,
// length); exactly one response per request, in request order.
// For each request, at the accept edge every cell compares
// its value with the item and registers the outcome; in the apply state
// the insert position is resolved from those flags, the cells shift or
// load in parallel, and the response register is written. A new request
// is not taken until the current one has been applied.
// While the response register is full and rsp_stall is high, the update
// waits and req_stall stays high, so no request is lost.
// Reset empties the list and the response register; stored values are
// not cleared, only the per-cell valid bits and the length counter.
`default_nettype none
module sorted_list_insert_find
   import slif_pkg::*;
(
   input  wire  logic    clock,
   input  wire  logic    reset,
   input  wire  logic    req_valid,
   output logic          req_stall,
   input  wire  req_type req_data,
   output logic          rsp_valid,
   input  wire  logic    rsp_stall,
   output rsp_type       rsp_data
);

   state_type        state_ff, state_in;
   op_type           op_ff;
   value_type        item_ff;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept, out_free, do_apply, full;
   value_type        req_value;
   ctl_type          ctl;
   logic [LEN_W-1:0] pos;

   value_type        value_q [CAPACITY];
   logic             valid_q [CAPACITY];
   logic             lt_q    [CAPACITY];
   stat_type         stat_q  [CAPACITY];
   logic             any_hit;

   assign req_value = to_value(req_data.item);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (length_ff == LEN_W'(CAPACITY));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_APPLY;
         ST_APPLY: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      do_apply  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_APPLY: do_apply  = out_free;
         default:  req_stall = 1'b1;
      endcase
   end

   // insert position from the registered pair flags
   always_comb begin
      pos = length_ff;
      for (int i = CAPACITY - 2; i >= 0; i--) begin
         if (stat_q[i].pair) begin
            pos = LEN_W'(i + 1);
         end
      end
      if (op_ff == OP_PUSH || length_ff == '0 || !stat_q[0].lt) begin
         pos = '0;
      end
   end

   always_comb begin
      any_hit = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_hit = any_hit | stat_q[i].hit;
      end
   end

   always_comb begin
      ctl.insert = do_apply && (op_ff == OP_INSERT || op_ff == OP_PUSH) && !full;
      ctl.clear  = do_apply && (op_ff == OP_CLEAR);
      ctl.pos    = pos;
      ctl.len    = length_ff;
      ctl.item   = item_ff;
   end

   always_comb begin
      length_in = length_ff;
      if (ctl.clear) begin
         length_in = '0;
      end else if (ctl.insert) begin
         length_in = length_ff + LEN_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (do_apply) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.found     = (op_ff == OP_FIND) && any_hit;
         rsp_data_in.full_drop = (op_ff == OP_INSERT || op_ff == OP_PUSH) && full;
         rsp_data_in.length    = LENGTH_W'(length_in);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         op_ff   <= req_data.operation;
         item_ff <= req_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      value_type left_value;
      logic      right_lt, right_valid;

      if (j == 0) begin : g_head
         assign left_value = item_ff;
      end else begin : g_body
         assign left_value = value_q[j-1];
      end

      if (j == CAPACITY - 1) begin : g_tail
         assign right_lt    = 1'b0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_lt    = lt_q[j+1];
         assign right_valid = valid_q[j+1];
      end

      slif_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .index       (IDX_W'(j)),
         .capture     (accept),
         .req_value   (req_value),
         .left_value  (left_value),
         .right_lt    (right_lt),
         .right_valid (right_valid),
         .ctl         (ctl),
         .lt_now      (lt_q[j]),
         .valid       (valid_q[j]),
         .value       (value_q[j]),
         .stat        (stat_q[j])
      );
   end

endmodule
`default_nettype wire

FILE: rtl/core/slif_cell.sv
`default_nettype none
module slif_cell
   import slif_pkg::*;
(
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  logic [IDX_W-1:0] index,
   input  wire  logic             capture,
   input  wire  value_type        req_value,
   input  wire  value_type        left_value,
   input  wire  logic             right_lt,
   input  wire  logic             right_valid,
   input  wire  ctl_type          ctl,
   output logic                   lt_now,
   output logic                   valid,
   output value_type              value,
   output stat_type               stat
);

   value_type  value_ff, value_in;
   logic       valid_ff, valid_in;
   stat_type   stat_ff, stat_in;
   logic [LEN_W-1:0] my_idx;
   logic       do_load, do_shift;

   assign my_idx = LEN_W'(index);
   assign lt_now = valid_ff && (value_ff < req_value);

   always_comb begin
      stat_in.lt   = lt_now;
      stat_in.pair = right_valid && lt_now && !right_lt;
      stat_in.hit  = valid_ff && (value_ff == req_value);
   end

   assign do_load  = ctl.insert && (my_idx == ctl.pos);
   assign do_shift = ctl.insert && (my_idx > ctl.pos) && (my_idx <= ctl.len);

   always_comb begin
      value_in = value_ff;
      if (do_load) begin
         value_in = ctl.item;
      end else if (do_shift) begin
         value_in = left_value;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert && (my_idx == ctl.len)) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (capture) begin
         stat_ff <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign stat  = stat_ff;

endmodule
`default_nettype wire

FILE: test/sorted_list_insert_find_test.sv
`default_nettype none
module sorted_list_insert_find_test;
   timeunit 1ns;
   timeprecision 1ps;

   import slif_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 100;
   localparam logic signed [ITEM_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [ITEM_W-1:0] MOST_POS = 32'sh7fff_ffff;

   typedef struct {
      op_type                   op;
      logic signed [ITEM_W-1:0] item;
      bit                       typed;
      rsp_type                  want;
   } step_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   value_type list_vals [CAPACITY];
   int        list_len = 0;
   rsp_type   pending_results [$];

   int cycles = 0;
   int errors = 0;
   int sent_count = 0;
   int checked_count = 0;
   int drop_count = 0;
   int hit_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   // empty list, extremes, unsorted contents after push front, stale values after clear
   step_type directed_steps [24] = '{
      '{OP_FIND,   32'sd0,         1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OP_INSERT, 32'sd0,         1'b1, '{1'b0, 1'b0, 7'd1}},
      '{OP_INSERT, MOST_NEG,       1'b1, '{1'b0, 1'b0, 7'd2}},
      '{OP_INSERT, MOST_POS,       1'b1, '{1'b0, 1'b0, 7'd3}},
      '{OP_FIND,   MOST_NEG,       1'b1, '{1'b1, 1'b0, 7'd3}},
      '{OP_FIND,   MOST_POS,       1'b1, '{1'b1, 1'b0, 7'd3}},
      '{OP_FIND,   -32'sd1,        1'b1, '{1'b0, 1'b0, 7'd3}},
      '{OP_PUSH,   -32'sd7,        1'b1, '{1'b0, 1'b0, 7'd4}},
      '{OP_INSERT, -32'sd8,        1'b0, '0},
      '{OP_INSERT, -32'sd6,        1'b0, '0},
      '{OP_INSERT, 32'sd100,       1'b0, '0},
      '{OP_INSERT, 32'sd0,         1'b0, '0},
      '{OP_FIND,   32'sd100,       1'b0, '0},
      '{OP_FIND,   32'sh5555_5555, 1'b0, '0},
      '{OP_CLEAR,  32'shaaaa_aaaa, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OP_FIND,   32'sd0,         1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OP_PUSH,   MOST_POS,       1'b1, '{1'b0, 1'b0, 7'd1}},
      '{OP_INSERT, MOST_POS,       1'b0, '0},
      '{OP_INSERT, MOST_NEG,       1'b0, '0},
      '{OP_PUSH,   MOST_NEG,       1'b0, '0},
      '{OP_INSERT, -32'sd1,        1'b0, '0},
      '{OP_FIND,   -32'sd1,        1'b0, '0},
      '{OP_CLEAR,  32'sd0,         1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OP_INSERT, 32'sd1,         1'b1, '{1'b0, 1'b0, 7'd1}}
   };

   sorted_list_insert_find DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type update_list(input req_type r);
      rsp_type   res;
      value_type v;
      int        pos;
      int        i;
      int        k;
      res = '0;
      v = value_type'(r.item);
      case (r.operation)
         OP_INSERT, OP_PUSH: begin
            if (list_len >= CAPACITY) begin
               res.full_drop = 1'b1;
            end else begin
               pos = list_len;
               if (r.operation == OP_PUSH || list_len == 0 || v <= list_vals[0]) begin
                  pos = 0;
               end else begin
                  for (i = 0; i + 1 < list_len; i++) begin
                     if (list_vals[i] < v && list_vals[i + 1] >= v) begin
                        pos = i + 1;
                        break;
                     end
                  end
               end
               for (k = list_len; k > pos; k--) list_vals[k] = list_vals[k - 1];
               list_vals[pos] = v;
               list_len++;
            end
         end
         OP_FIND: begin
            for (i = 0; i < list_len; i++) begin
               if (list_vals[i] == v) res.found = 1'b1;
            end
         end
         default: list_len = 0;
      endcase
      res.length = list_len[LENGTH_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 30) $display("mismatch at cycle %0d: %s", cycles, msg);
   endtask

   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      gap = 0;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predicted = update_list(r);
      pending_results.push_back(typed ? typed_rsp : predicted);
      sent_count++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_data.found) hit_count++;
            if (rsp_data.full_drop) drop_count++;
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %b, expected %b", rsp_data.found, want.found));
            if (rsp_data.full_drop !== want.full_drop)
               report_mismatch($sformatf("full_drop %b, expected %b",
                                         rsp_data.full_drop, want.full_drop));
            if (rsp_data.length !== want.length)
               report_mismatch($sformatf("length %0d, expected %0d",
                                         rsp_data.length, want.length));
         end
      end
   end

   initial begin : stimulus
      req_type r;
      int      phase;
      int      sent;
      int      span;
      int      pick;
      int      sel;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[n]) begin
         r.operation = directed_steps[n].op;
         r.item = directed_steps[n].item;
         send_request(r, directed_steps[n].typed, directed_steps[n].want);
      end

      for (phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 74 : (phase == 3) ? 23 : 0;
         stall_pct = (phase == 2) ? 74 : (phase == 3) ? 23 : 0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // long runs fill the list and exercise dropped inserts
            span = (sent == 0 || $urandom_range(3) == 0) ? $urandom_range(90, 130)
                                                         : $urandom_range(4, 40);
            r.operation = OP_CLEAR;
            r.item = $urandom;
            send_request(r, 1'b0, '0);
            sent++;
            if (span > PHASE_ITEMS - sent) span = PHASE_ITEMS - sent;
            repeat (span) begin
               pick = $urandom_range(99);
               r.operation = (pick < 55) ? OP_INSERT : (pick < 80) ? OP_PUSH : OP_FIND;
               sel = $urandom_range(9);
               if (sel < 4)
                  r.item = $urandom;
               else if (sel < 7)
                  r.item = int'($urandom_range(16)) - 8;
               else if (sel == 7 || list_len == 0)
                  r.item = $urandom_range(1) ? MOST_POS : MOST_NEG;
               else
                  r.item = list_vals[$urandom_range(list_len - 1)];
               send_request(r, 1'b0, '0);
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      stall_pct = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests, %0d responses checked over four handshake pressure phases",
               sent_count, checked_count);
      $display("%0d finds hit a stored value, %0d inserts dropped on a full list",
               hit_count, drop_count);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
